// ----- hdl/joystick_axis_conditioner_unit_macros.svh -----
// assertion macros for the joystick axis conditioner checker
`ifndef JOYSTICK_AXIS_CONDITIONER_UNIT_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define JAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("joystick conditioner check failed");

// next-cycle implication, off during reset
`define JAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("joystick conditioner check failed");

`endif

// ----- hdl/jac_pkg.sv -----
// shared constants and types of the joystick axis conditioner
`timescale 1ns / 1ps

package jac_pkg;

    localparam int SAMPLES_PER_AVERAGE = 25;
    localparam int SAMPLE_BITS         = 10;

    localparam int CNT_W       = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int SUM_W       = SAMPLE_BITS + CNT_W;
    localparam int RECIP_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    localparam int DATA_W = 15;
    localparam int MODE_W = 2;
    localparam int IDX_W  = 3;
    localparam int KIND_W = 2;

    localparam logic [IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [IDX_W-1:0] CFG_X_ZERO     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_X_MIN_SPAN = 3'd2;
    localparam logic [IDX_W-1:0] CFG_X_MAX_SPAN = 3'd3;
    localparam logic [IDX_W-1:0] CFG_Y_ZERO     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_Y_MIN_SPAN = 3'd5;
    localparam logic [IDX_W-1:0] CFG_Y_MAX_SPAN = 3'd6;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_JOY  = 2'd1;

    localparam logic [KIND_W-1:0] KIND_X = 2'd1;
    localparam logic [KIND_W-1:0] KIND_Y = 2'd2;

    localparam logic [DATA_W-1:0] ZERO_RESET     = 15'd192;
    localparam logic [DATA_W-1:0] MIN_SPAN_RESET = 15'd71;
    localparam logic [DATA_W-1:0] MAX_SPAN_RESET = 15'd61;

    localparam int LIN_NUMERATOR = 122880;
    localparam int LIN_W         = 17;
    localparam int OFS_W         = LIN_W + 1;
    localparam int MIN_AVERAGE   = 10;
    localparam int FULL_SCALE    = 255;
    localparam int LEVEL_LIMIT   = 127;
    localparam int SNAP_ON       = 96;
    localparam int SNAP_OFF      = 32;

    localparam int LEVEL_W = 8;
    localparam int MAG_W   = LEVEL_W - 1;

    localparam int DIV_N     = DATA_W + 8;
    localparam int DIV_CNT_W = $clog2(DIV_N + 1);

    localparam int USER_W  = KIND_W;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 24;
    localparam int OUT_PAD = OUT_W - (2 * LEVEL_W + 7);

    typedef struct packed {
        logic load;
        logic step;
        logic div_start;
        logic div_sel;
        logic offset;
        logic level;
        logic emit;
    } jac_cmd_t;

    typedef struct packed {
        logic full;
        logic avg_ok;
        logic div_done;
        logic direct;
        logic out_free;
    } jac_stat_t;

endpackage

// ----- hdl/joystick_axis_conditioner_unit.sv -----
// top level of the joystick axis conditioner
`timescale 1ns / 1ps

// Each input transaction is one tick carrying the key level and optionally one X or
// Y converter sample; each produces exactly one output transaction with both current
// axis levels, the updated flags and the one-shot direction and press events. A plain
// tick goes through the step state to the output state, which loads the output
// register; the input reopens in the cycle after that load. The tick that completes an
// average of SAMPLES_PER_AVERAGE samples goes on through two passes of the shared
// 23-step divider (linearisation, then span scaling) before the output state. The
// second pass is skipped when the offset-corrected value or the span is zero, and both
// passes are skipped when the average is 10 or less. A stalled output holds the block
// in the output state. The output register lets the next tick be accepted while a
// result waits to be taken. The user must write settings through cfg_we/cfg_index/cfg_data
// only while no transaction is in flight; the block does not enforce this.
module joystick_axis_conditioner_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [jac_pkg::IDX_W-1:0]     cfg_index,
    input  logic [jac_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // kind
    input  logic [jac_pkg::USER_W-1:0]    s_tuser,
    // sample_value [9:0], key_released [10], zero fill
    input  logic [jac_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // x_position [7:0], y_position [15:8], x_updated, y_updated, left_event,
    // right_event, up_event, down_event, press_event [22:16], zero fill
    output logic [jac_pkg::OUT_W-1:0]     m_tdata
);

    jac_pkg::jac_cmd_t  cmd;
    jac_pkg::jac_stat_t stat;

    jac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jac_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- hdl/jac_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module jac_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [jac_pkg::DIV_N-1:0]    dividend,
    input  logic [jac_pkg::DATA_W-1:0]   divisor,
    output logic                         done,
    output logic [jac_pkg::DIV_N-1:0]    quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [jac_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [jac_pkg::DATA_W-1:0]        rem_reg, rem_next;
    logic [jac_pkg::DATA_W-1:0]        dsr_reg, dsr_next;
    logic [jac_pkg::DIV_N-1:0]         quo_reg, quo_next;
    logic [jac_pkg::DATA_W:0]          trial;
    logic [jac_pkg::DATA_W:0]          diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[jac_pkg::DIV_N-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = jac_pkg::DIV_CNT_W'(jac_pkg::DIV_N);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[jac_pkg::DATA_W-1:0];
                quo_next = {quo_reg[jac_pkg::DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[jac_pkg::DATA_W-1:0];
                quo_next = {quo_reg[jac_pkg::DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - jac_pkg::DIV_CNT_W'(1);
            if (cnt_reg == jac_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/jac_dp.sv -----
// datapath: settings, accumulators, scaling, snap logic and output register
`timescale 1ns / 1ps

module jac_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [jac_pkg::IDX_W-1:0]     cfg_index,
    input  logic [jac_pkg::DATA_W-1:0]    cfg_data,
    input  logic [jac_pkg::USER_W-1:0]    s_tuser,
    input  logic [jac_pkg::IN_W-1:0]      s_tdata,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [jac_pkg::OUT_W-1:0]     m_tdata,
    input  jac_pkg::jac_cmd_t             cmd,
    output jac_pkg::jac_stat_t            stat
);

    // settings
    logic [jac_pkg::MODE_W-1:0]  mode_reg;
    logic [jac_pkg::DATA_W-1:0]  x_zero_reg, x_min_reg, x_max_reg;
    logic [jac_pkg::DATA_W-1:0]  y_zero_reg, y_min_reg, y_max_reg;

    // latched transaction
    logic [jac_pkg::KIND_W-1:0]      kind_reg;
    logic [jac_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic                            key_rel_reg;

    // axis state
    logic [jac_pkg::SUM_W-1:0]   x_sum_reg, x_sum_next, y_sum_reg, y_sum_next;
    logic [jac_pkg::CNT_W-1:0]   x_cnt_reg, x_cnt_next, y_cnt_reg, y_cnt_next;
    logic [jac_pkg::LEVEL_W-1:0] x_lvl_reg, x_lvl_next, y_lvl_reg, y_lvl_next;
    logic x_snap_reg, x_snap_next, y_snap_reg, y_snap_next;
    logic key_snap_reg, key_snap_next;

    // work registers
    logic [jac_pkg::SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic                            neg_reg, neg_next;
    logic                            ofs_zero_reg, ofs_zero_next;
    logic [jac_pkg::DATA_W-1:0]      mag_reg, mag_next;

    // result flags
    logic x_upd_reg, x_upd_next, y_upd_reg, y_upd_next;
    logic left_reg, left_next, right_reg, right_next;
    logic up_reg, up_next, down_reg, down_next;
    logic press_reg, press_next;

    logic                         out_valid_reg, out_valid_next;
    logic [jac_pkg::OUT_W-1:0]    out_data_reg, out_data_next;

    // combinational helpers
    logic                                 is_y;
    logic                                 sample_ok;
    logic [jac_pkg::SUM_W-1:0]            sel_sum, sum_add;
    logic [jac_pkg::CNT_W-1:0]            sel_cnt;
    logic [jac_pkg::SUM_W+jac_pkg::RECIP_W-1:0] avg_prod;
    logic [jac_pkg::DATA_W-1:0]           sel_zero, span;
    logic [jac_pkg::OFS_W-1:0]            ofs, ofs_abs;
    logic [jac_pkg::DIV_N-1:0]            div_dividend, div_q;
    logic [jac_pkg::DATA_W-1:0]           div_divisor;
    logic                                 div_done;
    logic [jac_pkg::MAG_W-1:0]            lvl_mag;
    logic [jac_pkg::LEVEL_W-1:0]          lvl;
    logic                                 snap_cur, ev_pos, ev_neg, snap_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= jac_pkg::MODE_NONE;
            x_zero_reg <= jac_pkg::ZERO_RESET;
            x_min_reg  <= jac_pkg::MIN_SPAN_RESET;
            x_max_reg  <= jac_pkg::MAX_SPAN_RESET;
            y_zero_reg <= jac_pkg::ZERO_RESET;
            y_min_reg  <= jac_pkg::MIN_SPAN_RESET;
            y_max_reg  <= jac_pkg::MAX_SPAN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jac_pkg::CFG_MODE:       mode_reg   <= cfg_data[jac_pkg::MODE_W-1:0];
                jac_pkg::CFG_X_ZERO:     x_zero_reg <= cfg_data;
                jac_pkg::CFG_X_MIN_SPAN: x_min_reg  <= cfg_data;
                jac_pkg::CFG_X_MAX_SPAN: x_max_reg  <= cfg_data;
                jac_pkg::CFG_Y_ZERO:     y_zero_reg <= cfg_data;
                jac_pkg::CFG_Y_MIN_SPAN: y_min_reg  <= cfg_data;
                jac_pkg::CFG_Y_MAX_SPAN: y_max_reg  <= cfg_data;
                default:                 mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= s_tuser;
            sample_reg  <= s_tdata[jac_pkg::SAMPLE_BITS-1:0];
            key_rel_reg <= s_tdata[jac_pkg::SAMPLE_BITS];
        end
    end

    assign is_y      = (kind_reg == jac_pkg::KIND_Y);
    assign sample_ok = (mode_reg == jac_pkg::MODE_JOY) &&
                       (kind_reg == jac_pkg::KIND_X || kind_reg == jac_pkg::KIND_Y);
    assign sel_sum   = is_y ? y_sum_reg : x_sum_reg;
    assign sel_cnt   = is_y ? y_cnt_reg : x_cnt_reg;
    assign sum_add   = sel_sum + jac_pkg::SUM_W'(sample_reg);
    assign avg_prod  = (jac_pkg::SUM_W + jac_pkg::RECIP_W)'(sum_add) *
                       (jac_pkg::SUM_W + jac_pkg::RECIP_W)'(jac_pkg::AVG_RECIP);
    assign sel_zero  = is_y ? y_zero_reg : x_zero_reg;
    assign span      = neg_reg ? (is_y ? y_min_reg : x_min_reg)
                               : (is_y ? y_max_reg : x_max_reg);
    assign snap_cur  = is_y ? y_snap_reg : x_snap_reg;

    // offset correction from the linearised value
    assign ofs     = jac_pkg::OFS_W'(div_q[jac_pkg::LIN_W-1:0]) - jac_pkg::OFS_W'(sel_zero);
    assign ofs_abs = ofs[jac_pkg::OFS_W-1] ? (~ofs + jac_pkg::OFS_W'(1)) : ofs;

    assign div_dividend = cmd.div_sel
        ? jac_pkg::DIV_N'(mag_reg) * jac_pkg::DIV_N'(jac_pkg::FULL_SCALE)
        : jac_pkg::DIV_N'(jac_pkg::LIN_NUMERATOR);
    assign div_divisor  = cmd.div_sel ? span : jac_pkg::DATA_W'(avg_reg);

    jac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // clamp, sign and snap hysteresis
    always_comb
    begin
        if (ofs_zero_reg)
            lvl_mag = '0;
        else if (span == '0)
            lvl_mag = jac_pkg::MAG_W'(jac_pkg::LEVEL_LIMIT);
        else if (div_q >= jac_pkg::DIV_N'(jac_pkg::LEVEL_LIMIT))
            lvl_mag = jac_pkg::MAG_W'(jac_pkg::LEVEL_LIMIT);
        else
            lvl_mag = div_q[jac_pkg::MAG_W-1:0];
        lvl      = neg_reg ? (~{1'b0, lvl_mag} + jac_pkg::LEVEL_W'(1)) : {1'b0, lvl_mag};
        ev_pos   = !neg_reg && (lvl_mag > jac_pkg::MAG_W'(jac_pkg::SNAP_ON)) && !snap_cur;
        ev_neg   = neg_reg && (lvl_mag > jac_pkg::MAG_W'(jac_pkg::SNAP_ON)) && !snap_cur;
        snap_new = (snap_cur || ev_pos || ev_neg) &&
                   !(lvl_mag < jac_pkg::MAG_W'(jac_pkg::SNAP_OFF));
    end

    always_comb
    begin
        x_sum_next     = x_sum_reg;
        y_sum_next     = y_sum_reg;
        x_cnt_next     = x_cnt_reg;
        y_cnt_next     = y_cnt_reg;
        x_lvl_next     = x_lvl_reg;
        y_lvl_next     = y_lvl_reg;
        x_snap_next    = x_snap_reg;
        y_snap_next    = y_snap_reg;
        key_snap_next  = key_snap_reg;
        avg_next       = avg_reg;
        neg_next       = neg_reg;
        ofs_zero_next  = ofs_zero_reg;
        mag_next       = mag_reg;
        x_upd_next     = x_upd_reg;
        y_upd_next     = y_upd_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        press_next     = press_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        if (cmd.load)
        begin
            x_upd_next = 1'b0;
            y_upd_next = 1'b0;
            left_next  = 1'b0;
            right_next = 1'b0;
            up_next    = 1'b0;
            down_next  = 1'b0;
            press_next = 1'b0;
        end

        if (cmd.step)
        begin
            // key edge detection
            if (mode_reg != jac_pkg::MODE_NONE)
            begin
                if (!key_rel_reg)
                begin
                    if (!key_snap_reg)
                        press_next = 1'b1;
                    key_snap_next = 1'b1;
                end
                else
                    key_snap_next = 1'b0;
            end
            if (sample_ok)
            begin
                if (stat.full)
                begin
                    avg_next = avg_prod[jac_pkg::RECIP_SHIFT +: jac_pkg::SAMPLE_BITS];
                    if (is_y)
                    begin
                        y_sum_next = '0;
                        y_cnt_next = '0;
                    end
                    else
                    begin
                        x_sum_next = '0;
                        x_cnt_next = '0;
                    end
                end
                else if (is_y)
                begin
                    y_sum_next = sum_add;
                    y_cnt_next = y_cnt_reg + jac_pkg::CNT_W'(1);
                end
                else
                begin
                    x_sum_next = sum_add;
                    x_cnt_next = x_cnt_reg + jac_pkg::CNT_W'(1);
                end
            end
        end

        if (cmd.offset)
        begin
            neg_next      = ofs[jac_pkg::OFS_W-1];
            ofs_zero_next = (ofs == '0);
            mag_next      = ofs_abs[jac_pkg::DATA_W-1:0];
        end

        if (cmd.level)
        begin
            if (is_y)
            begin
                y_lvl_next  = lvl;
                y_snap_next = snap_new;
                y_upd_next  = 1'b1;
                up_next     = ev_neg;
                down_next   = ev_pos;
            end
            else
            begin
                x_lvl_next  = lvl;
                x_snap_next = snap_new;
                x_upd_next  = 1'b1;
                left_next   = ev_neg;
                right_next  = ev_pos;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {jac_pkg::OUT_PAD'(0), press_reg, down_reg, up_reg, right_reg,
                              left_reg, y_upd_reg, x_upd_reg, y_lvl_reg, x_lvl_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_sum_reg     <= '0;
            y_sum_reg     <= '0;
            x_cnt_reg     <= '0;
            y_cnt_reg     <= '0;
            x_lvl_reg     <= '0;
            y_lvl_reg     <= '0;
            x_snap_reg    <= 1'b0;
            y_snap_reg    <= 1'b0;
            key_snap_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_sum_reg     <= x_sum_next;
            y_sum_reg     <= y_sum_next;
            x_cnt_reg     <= x_cnt_next;
            y_cnt_reg     <= y_cnt_next;
            x_lvl_reg     <= x_lvl_next;
            y_lvl_reg     <= y_lvl_next;
            x_snap_reg    <= x_snap_next;
            y_snap_reg    <= y_snap_next;
            key_snap_reg  <= key_snap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg      <= avg_next;
        neg_reg      <= neg_next;
        ofs_zero_reg <= ofs_zero_next;
        mag_reg      <= mag_next;
        x_upd_reg    <= x_upd_next;
        y_upd_reg    <= y_upd_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        up_reg       <= up_next;
        down_reg     <= down_next;
        press_reg    <= press_next;
        out_data_reg <= out_data_next;
    end

    assign stat.full     = sample_ok &&
                           (sel_cnt == jac_pkg::CNT_W'(jac_pkg::SAMPLES_PER_AVERAGE - 1));
    assign stat.avg_ok   = (avg_reg > jac_pkg::SAMPLE_BITS'(jac_pkg::MIN_AVERAGE));
    assign stat.div_done = div_done;
    assign stat.direct   = ofs_zero_reg || (span == '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hdl/jac_ctrl.sv -----
// controller state machine sequencing one transaction through the datapath
`timescale 1ns / 1ps

module jac_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  jac_pkg::jac_stat_t  stat,
    output jac_pkg::jac_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_STEP   = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_DIV1   = 4'd3;
    localparam logic [3:0] S_OFFSET = 4'd4;
    localparam logic [3:0] S_SCALE  = 4'd5;
    localparam logic [3:0] S_DIV2   = 4'd6;
    localparam logic [3:0] S_LEVEL  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.full ? S_CHECK : S_OUT;
            end
            S_CHECK:
            begin
                if (stat.avg_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV1;
                end
                else
                    state_next = S_OUT;
            end
            S_DIV1:
            begin
                if (stat.div_done)
                    state_next = S_OFFSET;
            end
            S_OFFSET:
            begin
                cmd.offset = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.div_sel = 1'b1;
                if (stat.direct)
                    state_next = S_LEVEL;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV2;
                end
            end
            S_DIV2:
            begin
                cmd.div_sel = 1'b1;
                if (stat.div_done)
                    state_next = S_LEVEL;
            end
            S_LEVEL:
            begin
                cmd.level  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ----- hdl/jac_chk.sv -----
// port-level checker for the joystick axis conditioner and its bind
`timescale 1ns / 1ps
`include "joystick_axis_conditioner_unit_macros.svh"

module jac_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [jac_pkg::OUT_W-1:0]     m_tdata
);

    // a stalled result holds
    `JAC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one tick in flight at a time
    `JAC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // positions never reach the most negative code
    `JAC_ASSERT_NOW(a_pos_range, clk, rst_n, m_tvalid, m_tdata[7:0] != 8'h80 && m_tdata[15:8] != 8'h80)
    // a sample updates at most one axis
    `JAC_ASSERT_NOW(a_one_axis, clk, rst_n, m_tvalid, !(m_tdata[16] && m_tdata[17]))
    // left and right events only come with a fresh X level
    `JAC_ASSERT_NOW(a_event_upd, clk, rst_n, m_tvalid && (m_tdata[18] || m_tdata[19]), m_tdata[16])

endmodule

bind joystick_axis_conditioner_unit jac_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/joystick_axis_conditioner_unit_tb.sv -----
// self-checking testbench for the joystick axis conditioner, with an in-bench predictor
`timescale 1ns / 1ps

module joystick_axis_conditioner_unit_tb;

    import jac_pkg::*;

    localparam logic [MODE_W-1:0] MODE_KEY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_THREE = 2'd3;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int DATA_MAX       = (1 << DATA_W) - 1;
    localparam int SETTLE_CYCLES  = 64;
    localparam int IDLE_LIMIT     = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 150;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   released;
    } joy_tick_t;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic               pad;
        logic               press;
        logic               down;
        logic               up;
        logic               right;
        logic               left;
        logic               y_upd;
        logic               x_upd;
        logic [LEVEL_W-1:0] y_pos;
        logic [LEVEL_W-1:0] x_pos;
    } joy_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [DATA_W-1:0]   cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // kind
    logic [USER_W-1:0]   s_tuser = '0;
    // sample_value [9:0], key_released [10], zero fill
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // x_position [7:0], y_position [15:8], x_updated, y_updated, left_event,
    // right_event, up_event, down_event, press_event [22:16], zero fill
    logic [OUT_W-1:0]    m_tdata;

    // register mirror, index 0 is X and 1 is Y
    logic [MODE_W-1:0]   mode_r = MODE_NONE;
    logic [DATA_W-1:0]   zero_r[2] = '{ZERO_RESET, ZERO_RESET};
    logic [DATA_W-1:0]   min_r[2] = '{MIN_SPAN_RESET, MIN_SPAN_RESET};
    logic [DATA_W-1:0]   max_r[2] = '{MAX_SPAN_RESET, MAX_SPAN_RESET};

    // predicted block state
    int                  sum_r[2] = '{0, 0};
    int                  count_r[2] = '{0, 0};
    int                  level_r[2] = '{0, 0};
    bit                  snapped_r[2] = '{1'b0, 1'b0};
    bit                  key_snapped = 1'b0;

    joy_tick_t           tick_q[$];
    joy_report_t         report_q[$];

    int                  mismatch_count = 0;
    int                  results_seen = 0;
    int                  idle_cycles = 0;
    bit                  tick_accepted = 1'b0;

    int                  burst_left = 0;
    int                  gap_left = 0;
    joy_tick_t           nxt_tick;

    int                  hold_left = 0;
    bit                  hold_done = 1'b0;
    int                  pat_sel = 0;
    int                  pat_left = 0;

    bit                  key_level = 1'b1;
    int                  target_avg[2] = '{0, 0};
    int                  axis_sent[2] = '{0, 0};

    joy_report_t         got_r;
    joy_report_t         want_r;

    joystick_axis_conditioner_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    // one sample into an axis average, level and snap events when the average completes
    function automatic void axis_accumulate(int ax, int sample, output bit upd,
                                            output bit neg_ev, output bit pos_ev);
        int avg;
        int v;
        upd = 1'b0;
        neg_ev = 1'b0;
        pos_ev = 1'b0;
        sum_r[ax] += sample;
        count_r[ax]++;
        if (count_r[ax] < SAMPLES_PER_AVERAGE)
            return;
        avg = sum_r[ax] / SAMPLES_PER_AVERAGE;
        sum_r[ax] = 0;
        count_r[ax] = 0;
        if (avg <= MIN_AVERAGE)
            return;
        v = LIN_NUMERATOR / avg - int'(zero_r[ax]);
        if (v < 0)
        begin
            if (min_r[ax] == '0)
                v = -LEVEL_LIMIT;
            else
                v = (v * FULL_SCALE) / int'(min_r[ax]);
        end
        else if (v > 0)
        begin
            if (max_r[ax] == '0)
                v = LEVEL_LIMIT;
            else
                v = (v * FULL_SCALE) / int'(max_r[ax]);
        end
        if (v < -LEVEL_LIMIT)
            v = -LEVEL_LIMIT;
        if (v > LEVEL_LIMIT)
            v = LEVEL_LIMIT;
        level_r[ax] = v;
        if (v > SNAP_ON && !snapped_r[ax])
        begin
            snapped_r[ax] = 1'b1;
            pos_ev = 1'b1;
        end
        if (v < -SNAP_ON && !snapped_r[ax])
        begin
            snapped_r[ax] = 1'b1;
            neg_ev = 1'b1;
        end
        if (v < SNAP_OFF && v > -SNAP_OFF)
            snapped_r[ax] = 1'b0;
        upd = 1'b1;
    endfunction

    function automatic joy_report_t predict_report(joy_tick_t t);
        joy_report_t r;
        bit upd;
        bit neg_ev;
        bit pos_ev;
        r = '0;
        if (mode_r != MODE_NONE)
        begin
            if (!t.released)
            begin
                if (!key_snapped)
                begin
                    r.press = 1'b1;
                    key_snapped = 1'b1;
                end
            end
            else
                key_snapped = 1'b0;
        end
        if (mode_r == MODE_JOY)
        begin
            if (t.kind == KIND_X)
            begin
                axis_accumulate(0, int'(t.sample), upd, neg_ev, pos_ev);
                r.x_upd = upd;
                r.left = neg_ev;
                r.right = pos_ev;
            end
            else if (t.kind == KIND_Y)
            begin
                axis_accumulate(1, int'(t.sample), upd, neg_ev, pos_ev);
                r.y_upd = upd;
                r.up = neg_ev;
                r.down = pos_ev;
            end
        end
        r.x_pos = LEVEL_W'(level_r[0]);
        r.y_pos = LEVEL_W'(level_r[1]);
        return r;
    endfunction

    // average to aim an axis at, mostly around the current centre and spans
    function automatic int pick_avg_target(int ax);
        int lo;
        int hi;
        int lin;
        int avg;
        lo = int'(min_r[ax]) * 3 / 2 + 2;
        hi = int'(max_r[ax]) * 3 / 2 + 2;
        if (lo > 4000)
            lo = 4000;
        if (hi > 4000)
            hi = 4000;
        case ($urandom_range(0, 15))
            0: avg = int'($urandom_range(0, 2 * MIN_AVERAGE));
            1: avg = int'($urandom_range(0, SAMPLE_MAX));
            default:
            begin
                lin = int'(zero_r[ax]) + int'($urandom_range(0, lo + hi)) - lo;
                if (lin <= LIN_NUMERATOR / SAMPLE_MAX)
                    lin = LIN_NUMERATOR / SAMPLE_MAX + 1;
                avg = LIN_NUMERATOR / lin;
                if (avg <= MIN_AVERAGE)
                    avg = MIN_AVERAGE + 1;
            end
        endcase
        return avg;
    endfunction

    task automatic push_tick(logic [KIND_W-1:0] kind, int sample, bit released);
        joy_tick_t t;
        t.kind = kind;
        t.sample = sample[SAMPLE_BITS-1:0];
        t.released = released;
        tick_q.push_back(t);
    endtask

    // runs of samples near a target per axis, with key edges and some noise
    task automatic gen_joystick_ticks(int count);
        joy_tick_t t;
        int ax;
        int s;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                key_level = ~key_level;
            t.released = key_level;
            case ($urandom_range(0, 19))
                0: t.kind = KIND_TICK;
                1: t.kind = KIND_SPARE;
                default: t.kind = $urandom_range(0, 1) ? KIND_X : KIND_Y;
            endcase
            ax = (t.kind == KIND_Y) ? 1 : 0;
            if (t.kind == KIND_X || t.kind == KIND_Y)
            begin
                if (axis_sent[ax] % SAMPLES_PER_AVERAGE == 0)
                    target_avg[ax] = pick_avg_target(ax);
                axis_sent[ax]++;
            end
            if ($urandom_range(0, 15) == 0)
                s = int'($urandom_range(0, SAMPLE_MAX));
            else
                s = target_avg[ax] + int'($urandom_range(0, 6)) - 3;
            if (s < 0)
                s = 0;
            if (s > SAMPLE_MAX)
                s = SAMPLE_MAX;
            t.sample = s[SAMPLE_BITS-1:0];
            tick_q.push_back(t);
        end
    endtask

    // nothing queued, nothing in flight, then room for a slow average to drain
    task automatic wait_idle();
        while (tick_q.size() != 0 || s_tvalid || report_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(logic [MODE_W-1:0] mode, int xz, int xmin, int xmax,
                                  int yz, int ymin, int ymax);
        int vals[7];
        vals = '{int'(mode), xz, xmin, xmax, yz, ymin, ymax};
        for (int i = 0; i < 7; i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data <= vals[i][DATA_W-1:0];
            case (IDX_W'(i))
                CFG_MODE:       mode_r = vals[i][MODE_W-1:0];
                CFG_X_ZERO:     zero_r[0] = vals[i][DATA_W-1:0];
                CFG_X_MIN_SPAN: min_r[0] = vals[i][DATA_W-1:0];
                CFG_X_MAX_SPAN: max_r[0] = vals[i][DATA_W-1:0];
                CFG_Y_ZERO:     zero_r[1] = vals[i][DATA_W-1:0];
                CFG_Y_MIN_SPAN: min_r[1] = vals[i][DATA_W-1:0];
                CFG_Y_MAX_SPAN: max_r[1] = vals[i][DATA_W-1:0];
                default:        ;
            endcase
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(string field, int got, int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: result %0d %s: got %0d, expected %0d", $realtime, results_seen,
                     field, got, want);
        mismatch_count++;
    endtask

    // driver: bursts of transactions with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || tick_accepted))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (tick_q.size() != 0)
            begin
                nxt_tick = tick_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= nxt_tick.kind;
                s_tdata <= IN_W'({nxt_tick.released, nxt_tick.sample});
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = int'($urandom_range(1, 24));
                    case ($urandom_range(0, 5))
                        0, 1: gap_left = 0;
                        2:    gap_left = int'($urandom_range(20, 40));
                        default: gap_left = int'($urandom_range(1, 8));
                    endcase
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: stall patterns, one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_sel = int'($urandom_range(0, 3));
                    pat_left = int'($urandom_range(8, 80));
                end
                pat_left--;
                case (pat_sel)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (pat_left % 3 != 0);
                endcase
            end
        end
    end

    // predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            tick_accepted = s_tvalid && s_tready;
            if (tick_accepted)
            begin
                nxt_tick.kind = s_tuser;
                nxt_tick.sample = s_tdata[SAMPLE_BITS-1:0];
                nxt_tick.released = s_tdata[SAMPLE_BITS];
                report_q.push_back(predict_report(nxt_tick));
            end
            if (m_tvalid && m_tready)
            begin
                got_r = m_tdata;
                if (report_q.size() == 0)
                    report_mismatch("transaction with no tick pending", int'(m_tdata), 0);
                else
                begin
                    want_r = report_q.pop_front();
                    if (got_r.x_pos !== want_r.x_pos)
                        report_mismatch("x_position", int'($signed(got_r.x_pos)),
                                        int'($signed(want_r.x_pos)));
                    if (got_r.y_pos !== want_r.y_pos)
                        report_mismatch("y_position", int'($signed(got_r.y_pos)),
                                        int'($signed(want_r.y_pos)));
                    if (got_r.x_upd !== want_r.x_upd)
                        report_mismatch("x_updated", got_r.x_upd, want_r.x_upd);
                    if (got_r.y_upd !== want_r.y_upd)
                        report_mismatch("y_updated", got_r.y_upd, want_r.y_upd);
                    if (got_r.left !== want_r.left)
                        report_mismatch("left_event", got_r.left, want_r.left);
                    if (got_r.right !== want_r.right)
                        report_mismatch("right_event", got_r.right, want_r.right);
                    if (got_r.up !== want_r.up)
                        report_mismatch("up_event", got_r.up, want_r.up);
                    if (got_r.down !== want_r.down)
                        report_mismatch("down_event", got_r.down, want_r.down);
                    if (got_r.press !== want_r.press)
                        report_mismatch("press_event", got_r.press, want_r.press);
                end
                results_seen++;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, mode none: key not watched, samples ignored
        push_tick(KIND_TICK, 0, 1'b1);
        push_tick(KIND_X, SAMPLE_MAX, 1'b0);
        push_tick(KIND_Y, 0, 1'b0);
        push_tick(KIND_SPARE, SAMPLE_MAX, 1'b1);
        push_tick(KIND_X, 'h2AA, 1'b1);
        push_tick(KIND_Y, 'h155, 1'b0);
        wait_idle();

        // key edges and the spare kind
        apply_settings(MODE_JOY, ZERO_RESET, MIN_SPAN_RESET, MAX_SPAN_RESET,
                       ZERO_RESET, MIN_SPAN_RESET, MAX_SPAN_RESET);
        push_tick(KIND_TICK, 0, 1'b1);
        push_tick(KIND_TICK, 0, 1'b0);
        push_tick(KIND_TICK, SAMPLE_MAX, 1'b0);
        push_tick(KIND_SPARE, SAMPLE_MAX, 1'b0);
        push_tick(KIND_TICK, 0, 1'b1);
        push_tick(KIND_X, 'h155, 1'b0);
        push_tick(KIND_Y, 'h2AA, 1'b1);
        push_tick(KIND_SPARE, 0, 1'b0);
        gen_joystick_ticks(260);
        wait_idle();

        apply_settings(MODE_KEY, ZERO_RESET, MIN_SPAN_RESET, MAX_SPAN_RESET,
                       ZERO_RESET, MIN_SPAN_RESET, MAX_SPAN_RESET);
        gen_joystick_ticks(40);
        wait_idle();

        apply_settings(MODE_THREE, ZERO_RESET, MIN_SPAN_RESET, MAX_SPAN_RESET,
                       ZERO_RESET, MIN_SPAN_RESET, MAX_SPAN_RESET);
        gen_joystick_ticks(30);
        wait_idle();

        // zero spans on X, widest settings on Y
        apply_settings(MODE_JOY, 600, 0, 0, DATA_MAX, DATA_MAX, DATA_MAX);
        gen_joystick_ticks(120);
        wait_idle();

        // key held state must survive mode none
        apply_settings(MODE_NONE, 0, 1, 1, 0, 1, 1);
        gen_joystick_ticks(30);
        wait_idle();

        apply_settings(MODE_JOY, 0, 1, 1, ZERO_RESET, FULL_SCALE, FULL_SCALE);
        gen_joystick_ticks(100);
        wait_idle();

        for (int p = 0; p < 2; p++)
        begin
            apply_settings(MODE_JOY, $urandom_range(120, 400), $urandom_range(1, 120),
                           $urandom_range(1, 120), $urandom_range(120, 400),
                           $urandom_range(1, 120), $urandom_range(1, 120));
            gen_joystick_ticks(125);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
